### rtl/psfe_pkg.sv
// ----------------------------------------------------------------------------
// psfe_pkg
// Shared types, codes and the byte-wise CRC-32 step of the PNG encoder.
// ----------------------------------------------------------------------------
package psfe_pkg;

  localparam logic [31:0] CrcPoly   = 32'hEDB88320;
  localparam logic [16:0] AdlerMod  = 17'd65521;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned IdxW      = 6;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;

  localparam logic [IdxW-1:0] StartLast   = 6'd42;
  localparam logic [IdxW-1:0] StartIdatLn = 6'd33;
  localparam logic [IdxW-1:0] EndLast     = 6'd19;
  localparam logic [IdxW-1:0] HdrLast     = 6'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_START,
    ST_RAW,
    ST_END
  } state_e;

  typedef enum logic [1:0] {
    SEL_START,
    SEL_HDR,
    SEL_RAW,
    SEL_END
  } sel_e;

  typedef struct packed {
    logic            emit;
    sel_e            sel;
    logic [IdxW-1:0] idx;
    logic            last;
    logic            fend;
    logic            take_px;
    logic            frame_init;
    logic            calc;
  } psfe_cmd_t;

  typedef struct packed {
    logic out_free;
    logic block_zero;
    logic raw_one;
    logic col_zero;
    logic div_done;
  } psfe_sts_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/psfe_if.sv
// ----------------------------------------------------------------------------
// psfe interfaces
// Pixel, byte and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface psfe_pix_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_rgb;
  modport source (output valid, output pixel_rgb, input ready);
  modport sink   (input valid, input pixel_rgb, output ready);
endinterface

interface psfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       file_end;
  modport source (output valid, output out_byte, output run_last, output file_end, input ready);
  modport sink   (input valid, input out_byte, input run_last, input file_end, output ready);
endinterface

interface psfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/psfe_ctrl.sv
// ----------------------------------------------------------------------------
// psfe_ctrl
// Sequencer: frame start, block headers, row bytes and trailer, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module psfe_ctrl
  import psfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      px_valid_i,
  output logic      px_ready_o,
  input  psfe_sts_t sts_i,
  output psfe_cmd_t cmd_o
);

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] hidx_q, hidx_d;
  logic [1:0]      ridx_q, ridx_d;
  logic            in_frame_q, in_frame_d;
  logic            tail_q, tail_d;
  logic            started_q, started_d;
  logic            acc;

  assign px_ready_o = (state_q == ST_IDLE);
  assign acc        = px_valid_i && px_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      hidx_q     <= '0;
      ridx_q     <= '0;
      in_frame_q <= 1'b0;
      tail_q     <= 1'b0;
      started_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      hidx_q     <= hidx_d;
      ridx_q     <= ridx_d;
      in_frame_q <= in_frame_d;
      tail_q     <= tail_d;
      started_q  <= started_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    hidx_d     = hidx_q;
    ridx_d     = ridx_q;
    in_frame_d = in_frame_q;
    tail_d     = tail_q;
    started_d  = started_q;
    cmd_o      = '{emit: 1'b0, sel: SEL_RAW, idx: idx_q, last: 1'b0, fend: 1'b0,
                   take_px: 1'b0, frame_init: 1'b0, calc: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          cmd_o.take_px = 1'b1;
          idx_d         = '0;
          hidx_d        = '0;
          if (tail_q) begin
            tail_d    = 1'b0;
            started_d = 1'b0;
            state_d   = ST_END;
          end else if (!in_frame_q) begin
            cmd_o.frame_init = 1'b1;
            in_frame_d       = 1'b1;
            started_d        = 1'b1;
            state_d          = ST_SIZE;
          end else begin
            started_d = 1'b0;
            ridx_d    = sts_i.col_zero ? 2'd0 : 2'd1;
            state_d   = ST_RAW;
          end
        end
      end
      ST_SIZE: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_START;
      end
      ST_START: begin
        cmd_o.sel = SEL_START;
        if (sts_i.out_free && (sts_i.div_done || idx_q != StartIdatLn)) begin
          cmd_o.emit = 1'b1;
          if (idx_q == StartLast) begin
            idx_d   = '0;
            ridx_d  = 2'd0;
            state_d = ST_RAW;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_RAW: begin
        if (sts_i.block_zero) begin
          cmd_o.sel = SEL_HDR;
          cmd_o.idx = hidx_q;
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            hidx_d     = (hidx_q == HdrLast) ? '0 : hidx_q + 1'b1;
          end
        end else begin
          cmd_o.sel  = SEL_RAW;
          cmd_o.idx  = {4'd0, ridx_q};
          cmd_o.last = (ridx_q == 2'd3) && (!sts_i.raw_one || started_q);
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            ridx_d     = ridx_q + 1'b1;
            if (ridx_q == 2'd3) begin
              if (sts_i.raw_one) begin
                in_frame_d = 1'b0;
                idx_d      = '0;
                if (started_q) begin
                  tail_d  = 1'b1;
                  state_d = ST_IDLE;
                end else begin
                  state_d = ST_END;
                end
              end else begin
                state_d = ST_IDLE;
              end
            end
          end
        end
      end
      ST_END: begin
        cmd_o.sel  = SEL_END;
        cmd_o.last = (idx_q == EndLast);
        cmd_o.fend = (idx_q == EndLast);
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (idx_q == EndLast) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/psfe_dp.sv
// ----------------------------------------------------------------------------
// psfe_dp
// Datapath: size regs, length calc by reciprocal multiply, CRC, Adler, byte mux.
// ----------------------------------------------------------------------------
module psfe_dp
  import psfe_pkg::*;
#(
  parameter int unsigned MaxDim   = 4096,
  parameter int unsigned EffBlock = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [23:0]         pixel_i,
  input  psfe_cmd_t           cmd_i,
  output psfe_sts_t           sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic                out_fend_o
);

  localparam logic [31:0] Eff32   = 32'(EffBlock);
  localparam logic [31:0] EffM1   = 32'(EffBlock - 1);
  // ceil(2^45 / EffBlock), exact quotient for dividends below 2^29
  localparam logic [63:0] Recip   = ((64'd1 << 45) + 64'(EffBlock) - 64'd1) / 64'(EffBlock);
  localparam logic [21:0] RecipLo = Recip[21:0];
  localparam logic [21:0] RecipHi = Recip[43:22];
  localparam logic [12:0] MaxDim13 = 13'((MaxDim > 8191) ? 8191 : MaxDim);

  logic [12:0] cfg_w_q, cfg_h_q, w_q, h_q, w_d, h_d, col_q, col_d;
  logic [23:0] px_q;
  logic [31:0] raw_q, raw_calc, raw_left_q, raw_left_d, idat_q, idat_d;
  logic [31:0] crc_q, crc_d, crc_src;
  logic [28:0] dvd_q, dvd_d, quot_q, quot_d;
  logic [50:0] plo_q, plo_d, phi_q, phi_d;
  logic [51:0] psum;
  logic [16:0] alow_s, ahigh_s;
  logic [15:0] alow_q, alow_d, ahigh_q, ahigh_d, fill_q, fill_d, blk_len, nlen;
  logic        dload_q, mul_q, sum_q, fin_q, ddone_q, ddone_d;
  logic        out_free, crc_en, crc_init, is_final;
  logic [7:0]  b, rawb;
  logic [14:0] w3;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q, out_fend_q;

  function automatic logic [12:0] clamp_dim(input logic [12:0] v);
    if (v == '0) return 13'd1;
    if ({19'd0, v} > 32'(MaxDim)) return MaxDim13;
    return v;
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign w3         = {1'b0, w_q, 1'b0} + {2'd0, w_q} + 15'd1;
  assign raw_calc   = {19'd0, h_q} * {17'd0, w3};
  assign blk_len    = (raw_left_q > Eff32) ? Eff32[15:0] : raw_left_q[15:0];
  assign nlen       = ~blk_len;
  assign is_final   = (raw_left_q <= Eff32);
  assign psum       = {1'b0, phi_q} + {23'd0, plo_q[50:22]};

  assign sts_o = '{out_free: out_free, block_zero: (fill_q == '0),
                   raw_one: (raw_left_q == 32'd1), col_zero: (col_q == '0),
                   div_done: ddone_q};

  always_comb begin
    unique case (cmd_i.idx[1:0])
      2'd0:    rawb = 8'h00;
      2'd1:    rawb = px_q[23:16];
      2'd2:    rawb = px_q[15:8];
      default: rawb = px_q[7:0];
    endcase
  end

  always_comb begin
    b        = 8'h00;
    crc_en   = 1'b0;
    crc_init = 1'b0;
    unique case (cmd_i.sel)
      SEL_START: begin
        crc_en   = (cmd_i.idx >= 6'd12 && cmd_i.idx <= 6'd28) || (cmd_i.idx >= 6'd37);
        crc_init = (cmd_i.idx == 6'd12) || (cmd_i.idx == 6'd37);
        unique case (cmd_i.idx)
          6'd0:  b = 8'h89;
          6'd1:  b = 8'h50;
          6'd2:  b = 8'h4E;
          6'd3:  b = 8'h47;
          6'd4:  b = 8'h0D;
          6'd5:  b = 8'h0A;
          6'd6:  b = 8'h1A;
          6'd7:  b = 8'h0A;
          6'd11: b = 8'd13;
          6'd12: b = 8'h49;
          6'd13: b = 8'h48;
          6'd14: b = 8'h44;
          6'd15: b = 8'h52;
          6'd18: b = {3'd0, w_q[12:8]};
          6'd19: b = w_q[7:0];
          6'd22: b = {3'd0, h_q[12:8]};
          6'd23: b = h_q[7:0];
          6'd24: b = 8'd8;
          6'd25: b = 8'd2;
          6'd29: b = ~crc_q[31:24];
          6'd30: b = ~crc_q[23:16];
          6'd31: b = ~crc_q[15:8];
          6'd32: b = ~crc_q[7:0];
          6'd33: b = idat_q[31:24];
          6'd34: b = idat_q[23:16];
          6'd35: b = idat_q[15:8];
          6'd36: b = idat_q[7:0];
          6'd37: b = 8'h49;
          6'd38: b = 8'h44;
          6'd39: b = 8'h41;
          6'd40: b = 8'h54;
          6'd41: b = 8'h78;
          6'd42: b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      SEL_HDR: begin
        crc_en = 1'b1;
        unique case (cmd_i.idx)
          6'd0:    b = {7'd0, is_final};
          6'd1:    b = blk_len[7:0];
          6'd2:    b = blk_len[15:8];
          6'd3:    b = nlen[7:0];
          default: b = nlen[15:8];
        endcase
      end
      SEL_RAW: begin
        crc_en = 1'b1;
        b      = rawb;
      end
      default: begin
        crc_en   = (cmd_i.idx <= 6'd3) || (cmd_i.idx >= 6'd12 && cmd_i.idx <= 6'd15);
        crc_init = (cmd_i.idx == 6'd12);
        unique case (cmd_i.idx)
          6'd0:  b = ahigh_q[15:8];
          6'd1:  b = ahigh_q[7:0];
          6'd2:  b = alow_q[15:8];
          6'd3:  b = alow_q[7:0];
          6'd4:  b = ~crc_q[31:24];
          6'd5:  b = ~crc_q[23:16];
          6'd6:  b = ~crc_q[15:8];
          6'd7:  b = ~crc_q[7:0];
          6'd12: b = 8'h49;
          6'd13: b = 8'h45;
          6'd14: b = 8'h4E;
          6'd15: b = 8'h44;
          6'd16: b = ~crc_q[31:24];
          6'd17: b = ~crc_q[23:16];
          6'd18: b = ~crc_q[15:8];
          6'd19: b = ~crc_q[7:0];
          default: b = 8'h00;
        endcase
      end
    endcase
  end

  assign crc_src = crc_init ? 32'hFFFF_FFFF : crc_q;
  assign alow_s  = {1'b0, alow_q} + {9'd0, rawb};

  always_comb begin
    w_d        = w_q;
    h_d        = h_q;
    col_d      = col_q;
    crc_d      = crc_q;
    alow_d     = alow_q;
    ahigh_d    = ahigh_q;
    fill_d     = fill_q;
    raw_left_d = raw_left_q;
    ahigh_s    = '0;
    if (cmd_i.frame_init) begin
      w_d     = clamp_dim(cfg_w_q);
      h_d     = clamp_dim(cfg_h_q);
      col_d   = '0;
      fill_d  = '0;
      alow_d  = 16'd1;
      ahigh_d = 16'd0;
    end
    if (cmd_i.emit && crc_en) crc_d = crc_byte(crc_src, b);
    if (cmd_i.emit && cmd_i.sel == SEL_HDR && cmd_i.idx == HdrLast) fill_d = blk_len;
    if (cmd_i.emit && cmd_i.sel == SEL_RAW) begin
      fill_d     = fill_q - 16'd1;
      raw_left_d = raw_left_q - 32'd1;
      alow_d     = (alow_s >= AdlerMod) ? 16'(alow_s - AdlerMod) : alow_s[15:0];
      ahigh_s    = {1'b0, ahigh_q} + {1'b0, alow_d};
      ahigh_d    = (ahigh_s >= AdlerMod) ? 16'(ahigh_s - AdlerMod) : ahigh_s[15:0];
      if (cmd_i.idx[1:0] == 2'd3) col_d = (col_q + 13'd1 >= w_q) ? '0 : col_q + 13'd1;
    end
    if (cmd_i.calc) raw_left_d = raw_calc;
  end

  // block count = ceil(raw / EffBlock): add, two half multiplies, shift, then length
  always_comb begin
    dvd_d   = dvd_q;
    plo_d   = plo_q;
    phi_d   = phi_q;
    quot_d  = quot_q;
    idat_d  = idat_q;
    ddone_d = ddone_q;
    if (cmd_i.frame_init) ddone_d = 1'b0;
    if (dload_q) dvd_d = raw_q[28:0] + EffM1[28:0];
    if (mul_q) begin
      plo_d = {22'd0, dvd_q} * {29'd0, RecipLo};
      phi_d = {22'd0, dvd_q} * {29'd0, RecipHi};
    end
    if (sum_q) quot_d = psum[51:23];
    if (fin_q) begin
      idat_d  = 32'd6 + raw_q + {1'b0, quot_q, 2'b00} + {3'd0, quot_q};
      ddone_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q     <= 13'd256;
      cfg_h_q     <= 13'd240;
      w_q         <= 13'd1;
      h_q         <= 13'd1;
      col_q       <= '0;
      fill_q      <= '0;
      raw_left_q  <= '0;
      crc_q       <= 32'hFFFF_FFFF;
      alow_q      <= 16'd1;
      ahigh_q     <= '0;
      dload_q     <= 1'b0;
      mul_q       <= 1'b0;
      sum_q       <= 1'b0;
      fin_q       <= 1'b0;
      ddone_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == RegFrameWidth)  cfg_w_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == RegFrameHeight) cfg_h_q <= cfg_data_i;
      w_q         <= w_d;
      h_q         <= h_d;
      col_q       <= col_d;
      fill_q      <= fill_d;
      raw_left_q  <= raw_left_d;
      crc_q       <= crc_d;
      alow_q      <= alow_d;
      ahigh_q     <= ahigh_d;
      dload_q     <= cmd_i.calc;
      mul_q       <= dload_q;
      sum_q       <= mul_q;
      fin_q       <= sum_q;
      ddone_q     <= ddone_d;
      if (out_free) out_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_px) px_q <= pixel_i;
    if (cmd_i.calc) raw_q <= raw_calc;
    dvd_q  <= dvd_d;
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    quot_q <= quot_d;
    idat_q <= idat_d;
    if (cmd_i.emit && out_free) begin
      out_byte_q <= b;
      out_last_q <= cmd_i.last;
      out_fend_q <= cmd_i.fend;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_fend_o  = out_fend_q;

endmodule

### rtl/png_stored_frame_encoder.sv
// ----------------------------------------------------------------------------
// png_stored_frame_encoder
// Streams RGB pixels out as an uncompressed PNG file, one byte per transfer.
// ----------------------------------------------------------------------------
// Channels: pix_i takes one 24-bit RGB pixel per transfer in raster order;
// out_o gives one file byte per transfer, run_last on the last byte a pixel
// causes, file_end on the last IEND byte; cfg_i writes frame_width (index 0)
// and frame_height (index 1), sampled at the first pixel of each frame.
// A pixel is taken only while the sequencer is idle; it then emits its bytes
// at one per cycle while the receiver is ready, from a single output register:
// 3 pixel bytes, plus a row filter byte at each row start and 5 bytes for each
// stored-block header, then returns to idle. The first pixel of a frame adds
// 43 header bytes and a setup state; the IDAT length comes from a reciprocal
// multiply pipeline; the header waits at that field until it is done. The last
// pixel adds 20 trailer bytes; for a one-pixel frame they go out on the next
// transfer. Reset restores 256 x 240 and the frame start. A stalled receiver
// holds the output register and the sequencer waits; nothing is dropped.
// ----------------------------------------------------------------------------
module png_stored_frame_encoder
  import psfe_pkg::*;
#(
  parameter int unsigned MAX_DIM          = 4096,
  parameter int unsigned STORED_BLOCK_MAX = 65535
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  psfe_pix_if.sink    pix_i,
  psfe_cfg_if.sink    cfg_i,
  psfe_byte_if.source out_o
);

  localparam int unsigned EffBlock = (STORED_BLOCK_MAX < 4) ? 4 : STORED_BLOCK_MAX;

  psfe_cmd_t cmd;
  psfe_sts_t sts;

  assign cfg_i.ready = 1'b1;

  psfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .px_valid_i (pix_i.valid),
    .px_ready_o (pix_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psfe_dp #(
    .MaxDim   (MAX_DIM),
    .EffBlock (EffBlock)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .pixel_i     (pix_i.pixel_rgb),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.run_last),
    .out_fend_o  (out_o.file_end)
  );

endmodule

### rtl/psfe_checker.sv
// ----------------------------------------------------------------------------
// psfe_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module psfe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic pix_valid,
  input logic pix_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic out_fend
);

  a_fend_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_fend |-> out_last)
    else $error("file_end without run_last");

  a_one_pixel_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid && pix_ready |=> !pix_ready)
    else $error("pixel taken while previous still in work");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output dropped under stall");

endmodule

bind png_stored_frame_encoder psfe_checker u_psfe_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .pix_valid (pix_i.valid),
  .pix_ready (pix_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_last  (out_o.run_last),
  .out_fend  (out_o.file_end)
);
